// ----- sv/clwc_pkg.sv -----
// shared types and constants for the camera line window capture block
package clwc_pkg;

   // capture buffer depth and the width of a write index that can hold it
   localparam int BUF_DEPTH   = 65536;
   localparam int WR_IDX_W    = $clog2(BUF_DEPTH + 1);

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 48;
   localparam int RSP_USER_W  = 2;
   localparam int LINE_CNT_W  = 9;
   localparam int LINE_BYTE_W = 12;

   // output queue
   localparam int OQ_DEPTH    = 4;
   localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);
   localparam int OQ_PUSH_W   = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_LINE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_LINE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEEP_EVEN  = 2'd2;

   // result kinds
   localparam logic [RSP_USER_W-1:0] KIND_BYTE  = 2'd0;
   localparam logic [RSP_USER_W-1:0] KIND_LINE  = 2'd1;
   localparam logic [RSP_USER_W-1:0] KIND_FRAME = 2'd2;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_WAIT_RISE = 5'b00010,
      PH_WAIT_FALL = 5'b00100,
      PH_SCAN      = 5'b01000,
      PH_LINE      = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [RSP_USER_W-1:0]  kind;
      logic                   last;
      logic [15:0]            byte_index;
      logic [7:0]             data_byte;
      logic [7:0]             line_index;
      logic [LINE_BYTE_W-1:0] line_bytes;
      logic                   overflow;
   } rsp_beat_type;

endpackage

// ----- sv/camera_line_window_capture.sv -----
// camera line window capture: pin sample decoding, window logic and output queue
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tdata pin sample, tuser arm flag
//   rsp     | out | rsp_tvalid/tready    | tdata result fields, tuser kind, tlast
//   csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// one sample beat is taken per cycle while req_tready is high; its results are queued
// the same cycle and leave one per cycle while rsp_tready is high, so two results of
// one sample take two output beats. the four-entry output queue holds req_tready low
// only when fewer than two entries are free. csr writes are always taken. reset idles
// the phase, clears edge detectors and counters, and sets the registers to 0, 255, 1.
module camera_line_window_capture (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] vsync, [1] href, [2] pclk, [10:3] pixel_data, [15:11] zero
   input  logic [clwc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] mode
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] byte_index, [23:16] data_byte, [31:24] line_index,
   // [43:32] line_bytes, [44] overflow, [47:45] zero
   output logic [clwc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] kind
   output logic [clwc_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [clwc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [clwc_pkg::CSR_DATA_W-1:0]    csr_data
);

   // config registers
   logic [7:0] first_line_ff, first_line_in;
   logic [7:0] stop_line_ff, stop_line_in;
   logic       keep_even_ff, keep_even_in;

   // capture state
   clwc_pkg::phase_type                phase_ff, phase_in;
   logic                               prev_vsync_ff, prev_vsync_in;
   logic                               prev_href_ff, prev_href_in;
   logic                               prev_pclk_ff, prev_pclk_in;
   logic [clwc_pkg::LINE_CNT_W-1:0]    line_cnt_ff, line_cnt_in;
   logic                               parity_ff, parity_in;
   logic [clwc_pkg::WR_IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [clwc_pkg::LINE_BYTE_W-1:0]   line_bytes_ff, line_bytes_in;
   logic                               dropped_ff, dropped_in;

   // output queue
   clwc_pkg::rsp_beat_type             oq_ff [clwc_pkg::OQ_DEPTH];
   logic [clwc_pkg::OQ_PTR_W-1:0]      oq_wr_ff, oq_wr_in;
   logic [clwc_pkg::OQ_PTR_W-1:0]      oq_rd_ff, oq_rd_in;
   logic [clwc_pkg::OQ_CNT_W-1:0]      oq_cnt_ff, oq_cnt_in;

   logic                    req_beat, rsp_beat, csr_beat;
   logic                    mode, vsync, href, pclk;
   logic [7:0]              pixel;
   logic                    vs_rise;
   logic                    res_a_vld, res_b_vld;
   clwc_pkg::rsp_beat_type  res_a, res_b, frame_res;
   logic [clwc_pkg::OQ_PUSH_W-1:0] push_cnt;
   logic [clwc_pkg::OQ_PTR_W-1:0] oq_wr_next;
   clwc_pkg::rsp_beat_type  head;

   assign req_tready = (oq_cnt_ff <= clwc_pkg::OQ_CNT_W'(clwc_pkg::OQ_DEPTH - 2));
   assign csr_ready  = 1'b1;
   assign req_beat   = req_tvalid & req_tready;
   assign rsp_beat   = rsp_tvalid & rsp_tready;
   assign csr_beat   = csr_valid & csr_ready;

   assign mode  = req_tuser;
   assign vsync = req_tdata[0];
   assign href  = req_tdata[1];
   assign pclk  = req_tdata[2];
   assign pixel = req_tdata[10:3];

   assign vs_rise = vsync & ~prev_vsync_ff;

   always_comb begin
      frame_res            = '0;
      frame_res.kind       = clwc_pkg::KIND_FRAME;
      frame_res.overflow   = dropped_ff;
   end

   // config writes
   always_comb begin
      first_line_in = first_line_ff;
      stop_line_in  = stop_line_ff;
      keep_even_in  = keep_even_ff;
      if (csr_beat) begin
         case (csr_index)
            clwc_pkg::REG_FIRST_LINE: first_line_in = csr_data;
            clwc_pkg::REG_STOP_LINE:  stop_line_in  = csr_data;
            clwc_pkg::REG_KEEP_EVEN:  keep_even_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   // per-sample step
   always_comb begin
      phase_in      = phase_ff;
      prev_vsync_in = prev_vsync_ff;
      prev_href_in  = prev_href_ff;
      prev_pclk_in  = prev_pclk_ff;
      line_cnt_in   = line_cnt_ff;
      parity_in     = parity_ff;
      wr_idx_in     = wr_idx_ff;
      line_bytes_in = line_bytes_ff;
      dropped_in    = dropped_ff;
      res_a_vld     = 1'b0;
      res_b_vld     = 1'b0;
      res_a         = '0;
      res_b         = '0;

      if (req_beat) begin
         if (mode) begin
            phase_in      = clwc_pkg::PH_WAIT_RISE;
            prev_vsync_in = vsync;
            prev_href_in  = href;
            prev_pclk_in  = pclk;
            line_cnt_in   = '0;
            parity_in     = 1'b1;
            wr_idx_in     = '0;
            line_bytes_in = '0;
            dropped_in    = 1'b0;
         end else begin
            unique case (phase_ff)
               clwc_pkg::PH_IDLE: ;
               clwc_pkg::PH_WAIT_RISE: begin
                  if (vs_rise) phase_in = clwc_pkg::PH_WAIT_FALL;
                  prev_vsync_in = vsync;
               end
               clwc_pkg::PH_WAIT_FALL: begin
                  if (~vsync & prev_vsync_ff) begin
                     phase_in     = clwc_pkg::PH_SCAN;
                     prev_href_in = href;
                  end
                  prev_vsync_in = vsync;
               end
               clwc_pkg::PH_SCAN: begin
                  prev_href_in = href;
                  if (href & ~prev_href_ff &&
                      line_cnt_ff >= {1'b0, first_line_ff}) begin
                     // window line start or stop line: vsync is not looked at
                     if (line_cnt_ff == {1'b0, stop_line_ff}) begin
                        res_a_vld = 1'b1;
                        res_a     = frame_res;
                        phase_in  = clwc_pkg::PH_IDLE;
                     end else begin
                        phase_in      = clwc_pkg::PH_LINE;
                        prev_pclk_in  = pclk;
                        line_bytes_in = '0;
                     end
                  end else begin
                     if (href & ~prev_href_ff && line_cnt_ff != '1)
                        line_cnt_in = line_cnt_ff + 1'b1;
                     if (vs_rise) begin
                        res_a_vld = 1'b1;
                        res_a     = frame_res;
                        phase_in  = clwc_pkg::PH_IDLE;
                     end
                     prev_vsync_in = vsync;
                  end
               end
               clwc_pkg::PH_LINE: begin
                  prev_pclk_in = pclk;
                  if (href) begin
                     if (pclk & ~prev_pclk_ff) begin
                        if (parity_ff == keep_even_ff) begin
                           if (wr_idx_ff < clwc_pkg::WR_IDX_W'(clwc_pkg::BUF_DEPTH)) begin
                              res_a_vld            = 1'b1;
                              res_a.kind           = clwc_pkg::KIND_BYTE;
                              res_a.byte_index     = 16'(wr_idx_ff);
                              res_a.data_byte      = pixel;
                              wr_idx_in            = wr_idx_ff + 1'b1;
                              if (line_bytes_ff != '1)
                                 line_bytes_in = line_bytes_ff + 1'b1;
                           end else begin
                              dropped_in = 1'b1;
                           end
                        end
                        parity_in = ~parity_ff;
                     end
                  end else begin
                     // href fall closes the line
                     res_a_vld        = 1'b1;
                     res_a.kind       = clwc_pkg::KIND_LINE;
                     res_a.line_index = 8'(line_cnt_ff - {1'b0, first_line_ff});
                     res_a.line_bytes = line_bytes_ff;
                     if (line_cnt_ff != '1)
                        line_cnt_in = line_cnt_ff + 1'b1;
                     line_bytes_in = '0;
                     phase_in      = clwc_pkg::PH_SCAN;
                     prev_href_in  = 1'b0;
                     if (vs_rise) begin
                        res_b_vld = 1'b1;
                        res_b     = frame_res;
                        phase_in  = clwc_pkg::PH_IDLE;
                     end
                     prev_vsync_in = vsync;
                  end
               end
               default: ;
            endcase
         end
      end
      res_a.last = res_a_vld & ~res_b_vld;
      res_b.last = res_b_vld;
   end

   // output queue pointers
   always_comb begin
      push_cnt   = clwc_pkg::OQ_PUSH_W'(res_a_vld) + clwc_pkg::OQ_PUSH_W'(res_b_vld);
      oq_wr_next = oq_wr_ff + 1'b1;
      oq_wr_in   = oq_wr_ff + clwc_pkg::OQ_PTR_W'(push_cnt);
      oq_rd_in   = rsp_beat ? oq_rd_ff + 1'b1 : oq_rd_ff;
      oq_cnt_in  = oq_cnt_ff + clwc_pkg::OQ_CNT_W'(push_cnt)
                   - clwc_pkg::OQ_CNT_W'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (res_a_vld) oq_ff[oq_wr_ff]   <= res_a;
      if (res_b_vld) oq_ff[oq_wr_next] <= res_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_line_ff <= '0;
         stop_line_ff  <= 8'hFF;
         keep_even_ff  <= 1'b1;
         phase_ff      <= clwc_pkg::PH_IDLE;
         prev_vsync_ff <= 1'b0;
         prev_href_ff  <= 1'b0;
         prev_pclk_ff  <= 1'b0;
         line_cnt_ff   <= '0;
         parity_ff     <= 1'b1;
         wr_idx_ff     <= '0;
         line_bytes_ff <= '0;
         dropped_ff    <= 1'b0;
         oq_wr_ff      <= '0;
         oq_rd_ff      <= '0;
         oq_cnt_ff     <= '0;
      end else begin
         first_line_ff <= first_line_in;
         stop_line_ff  <= stop_line_in;
         keep_even_ff  <= keep_even_in;
         phase_ff      <= phase_in;
         prev_vsync_ff <= prev_vsync_in;
         prev_href_ff  <= prev_href_in;
         prev_pclk_ff  <= prev_pclk_in;
         line_cnt_ff   <= line_cnt_in;
         parity_ff     <= parity_in;
         wr_idx_ff     <= wr_idx_in;
         line_bytes_ff <= line_bytes_in;
         dropped_ff    <= dropped_in;
         oq_wr_ff      <= oq_wr_in;
         oq_rd_ff      <= oq_rd_in;
         oq_cnt_ff     <= oq_cnt_in;
      end
   end

   assign head       = oq_ff[oq_rd_ff];
   assign rsp_tvalid = (oq_cnt_ff != '0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {3'b000, head.overflow, head.line_bytes, head.line_index,
                        head.data_byte, head.byte_index};

endmodule

// ----- sim/tb_camera_line_window_capture.sv -----
// self-checking testbench for the camera line window capture block
`timescale 1ns / 100ps

module tb_camera_line_window_capture;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [clwc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [clwc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [clwc_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [clwc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [clwc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   camera_line_window_capture dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // capture model state and its copy of the registers
   logic [7:0]                   cfg_first_line = 8'd0;
   logic [7:0]                   cfg_stop_line = 8'd255;
   logic                         cfg_keep_even = 1'b1;
   clwc_pkg::phase_type          cam_phase = clwc_pkg::PH_IDLE;
   logic                         last_vsync = 1'b0;
   logic                         last_href = 1'b0;
   logic                         last_pclk = 1'b0;
   logic [8:0]                   frame_line = '0;
   logic                         keep_toggle = 1'b1;
   logic [clwc_pkg::WR_IDX_W-1:0] store_addr = '0;
   logic [11:0]                  bytes_in_line = '0;
   logic                         bytes_dropped = 1'b0;

   clwc_pkg::rsp_beat_type due_beats[$];
   int mismatch_count = 0;
   int samples_sent = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int quiet_cycles = 0;

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic rare();
      return ($urandom_range(99) < 8);
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic void bump_frame_line();
      if (frame_line != 9'd511) frame_line++;
   endfunction

   function automatic clwc_pkg::rsp_beat_type frame_done_beat();
      clwc_pkg::rsp_beat_type b;
      b = '0;
      b.kind = clwc_pkg::KIND_FRAME;
      b.overflow = bytes_dropped;
      cam_phase = clwc_pkg::PH_IDLE;
      return b;
   endfunction

   // works out the result beats of one accepted pin sample or arm beat
   task automatic camera_capture_step(input logic arm, vs, hr, pc, input logic [7:0] px);
      clwc_pkg::rsp_beat_type beats[2];
      int n;
      logic [8:0] rel_line;
      n = 0;
      if (arm) begin
         cam_phase = clwc_pkg::PH_WAIT_RISE;
         last_vsync = vs;
         last_href = hr;
         last_pclk = pc;
         frame_line = '0;
         keep_toggle = 1'b1;
         store_addr = '0;
         bytes_in_line = '0;
         bytes_dropped = 1'b0;
      end else begin
         case (cam_phase)
            clwc_pkg::PH_WAIT_RISE: begin
               if (vs && !last_vsync) cam_phase = clwc_pkg::PH_WAIT_FALL;
               last_vsync = vs;
            end
            clwc_pkg::PH_WAIT_FALL: begin
               if (!vs && last_vsync) begin
                  cam_phase = clwc_pkg::PH_SCAN;
                  last_href = hr;
               end
               last_vsync = vs;
            end
            clwc_pkg::PH_SCAN: begin
               // a window line entry skips the vsync check
               if (hr && !last_href && frame_line >= cfg_first_line) begin
                  last_href = hr;
                  if (frame_line == cfg_stop_line) begin
                     beats[n] = frame_done_beat();
                     n++;
                  end else begin
                     cam_phase = clwc_pkg::PH_LINE;
                     last_pclk = pc;
                     bytes_in_line = '0;
                  end
               end else begin
                  if (hr && !last_href) bump_frame_line();
                  last_href = hr;
                  if (vs && !last_vsync) begin
                     beats[n] = frame_done_beat();
                     n++;
                  end
                  last_vsync = vs;
               end
            end
            clwc_pkg::PH_LINE: begin
               if (hr) begin
                  if (pc && !last_pclk) begin
                     if (keep_toggle == cfg_keep_even) begin
                        if (store_addr < clwc_pkg::BUF_DEPTH) begin
                           beats[n] = '0;
                           beats[n].kind = clwc_pkg::KIND_BYTE;
                           beats[n].byte_index = store_addr[15:0];
                           beats[n].data_byte = px;
                           n++;
                           store_addr++;
                           if (bytes_in_line != 12'hFFF) bytes_in_line++;
                        end else begin
                           bytes_dropped = 1'b1;
                        end
                     end
                     keep_toggle = ~keep_toggle;
                  end
                  last_pclk = pc;
               end else begin
                  last_pclk = pc;
                  rel_line = frame_line - {1'b0, cfg_first_line};
                  beats[n] = '0;
                  beats[n].kind = clwc_pkg::KIND_LINE;
                  beats[n].line_index = rel_line[7:0];
                  beats[n].line_bytes = bytes_in_line;
                  n++;
                  bump_frame_line();
                  bytes_in_line = '0;
                  cam_phase = clwc_pkg::PH_SCAN;
                  last_href = 1'b0;
                  // vsync held during the line, so a rise shows up here
                  if (vs && !last_vsync) begin
                     beats[n] = frame_done_beat();
                     n++;
                  end
                  last_vsync = vs;
               end
            end
            default: ;
         endcase
      end
      if (n > 0) beats[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) due_beats.push_back(beats[i]);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got, exp);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, exp, $time);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      clwc_pkg::rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_beats.size() == 0) begin
            report_mismatch("beat with nothing due, kind", rsp_tuser, 0);
         end else begin
            want = due_beats.pop_front();
            if (rsp_tuser !== want.kind) report_mismatch("kind", rsp_tuser, want.kind);
            if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
            if (rsp_tdata[15:0] !== want.byte_index)
               report_mismatch("byte_index", rsp_tdata[15:0], want.byte_index);
            if (rsp_tdata[23:16] !== want.data_byte)
               report_mismatch("data_byte", rsp_tdata[23:16], want.data_byte);
            if (rsp_tdata[31:24] !== want.line_index)
               report_mismatch("line_index", rsp_tdata[31:24], want.line_index);
            if (rsp_tdata[43:32] !== want.line_bytes)
               report_mismatch("line_bytes", rsp_tdata[43:32], want.line_bytes);
            if (rsp_tdata[44] !== want.overflow)
               report_mismatch("overflow", rsp_tdata[44], want.overflow);
            if (rsp_tdata[47:45] !== 3'b000) report_mismatch("pad", rsp_tdata[47:45], 0);
         end
      end
   end

   // ends the run when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("camera_line_window_capture regression: fail");
         $finish;
      end
   end

   task automatic send_sample(input logic arm, vs, hr, pc, input logic [7:0] px);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= arm;
      req_tdata <= {5'b0, px, pc, hr, vs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      camera_capture_step(arm, vs, hr, pc, px);
      samples_sent++;
   endtask

   // stop sending and wait for every due beat, then for the block to settle
   task automatic flush_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [clwc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         clwc_pkg::REG_FIRST_LINE: cfg_first_line = value;
         clwc_pkg::REG_STOP_LINE:  cfg_stop_line = value;
         clwc_pkg::REG_KEEP_EVEN:  cfg_keep_even = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_window(input logic [7:0] first, stop, input logic keep_even);
      flush_results();
      write_reg(clwc_pkg::REG_FIRST_LINE, first);
      write_reg(clwc_pkg::REG_STOP_LINE, stop);
      write_reg(clwc_pkg::REG_KEEP_EVEN, {7'b0, keep_even});
   endtask

   task automatic set_idling(input int sender_pct, receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
   endtask

   // vsync low, high, low; leaves the capture scanning for lines
   task automatic vsync_pulse();
      send_sample(1'b0, 1'b0, coin(), coin(), any_byte());
      send_sample(1'b0, 1'b1, coin(), coin(), any_byte());
      send_sample(1'b0, 1'b0, 1'b0, coin(), any_byte());
   endtask

   task automatic scan_line(input int pulses, input logic vs_on_entry, vs_at_fall);
      send_sample(1'b0, vs_on_entry, 1'b1, coin(), any_byte());
      repeat (pulses) begin
         send_sample(1'b0, 1'b0, 1'b1, 1'b1, any_byte());
         send_sample(1'b0, 1'b0, 1'b1, 1'b0, any_byte());
      end
      send_sample(1'b0, vs_at_fall, 1'b0, coin(), any_byte());
   endtask

   task automatic random_frame();
      int lines;
      send_sample(1'b1, coin(), coin(), coin(), any_byte());
      if ($urandom_range(99) < 10)
         repeat ($urandom_range(1, 4)) send_sample(1'b0, coin(), coin(), coin(), any_byte());
      vsync_pulse();
      lines = $urandom_range(1, 7);
      repeat (lines) begin
         // stray pin states, now and then an arm in the middle of a frame
         if ($urandom_range(99) < 5) send_sample(coin(), coin(), coin(), coin(), any_byte());
         repeat ($urandom_range(0, 2)) send_sample(1'b0, rare(), 1'b0, coin(), any_byte());
         scan_line($urandom_range(0, 6), rare(), rare());
      end
      send_sample(1'b0, 1'b1, 1'b0, coin(), any_byte());
   endtask

   task automatic test_directed();
      send_sample(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);   // no capture armed yet
      send_sample(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
      vsync_pulse();
      send_sample(1'b0, 1'b1, 1'b1, 1'b0, 8'h00);   // vsync high on line entry
      send_sample(1'b0, 1'b0, 1'b1, 1'b1, 8'hFF);
      send_sample(1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
      send_sample(1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
      send_sample(1'b0, 1'b0, 1'b1, 1'b0, 8'hFF);
      send_sample(1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
      send_sample(1'b0, 1'b1, 1'b1, 1'b0, 8'hFF);
      // href falls with a pclk rise and vsync up: line count then frame done
      send_sample(1'b0, 1'b1, 1'b0, 1'b1, 8'hFF);
      send_sample(1'b1, 1'b1, 1'b1, 1'b1, 8'hA5);
      send_sample(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
      send_sample(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
      send_sample(1'b1, 1'b0, 1'b0, 1'b0, 8'h5A);   // restart while waiting for vsync fall
      vsync_pulse();
      scan_line(1, 1'b0, 1'b0);
      send_sample(1'b0, 1'b1, 1'b0, 1'b0, 8'h81);
   endtask

   task automatic test_window_limits();
      set_window(8'd0, 8'd0, 1'b0);
      send_sample(1'b1, coin(), coin(), coin(), any_byte());
      vsync_pulse();
      send_sample(1'b0, 1'b0, 1'b1, 1'b0, any_byte());
      set_window(8'd2, 8'd4, 1'b0);
      send_sample(1'b1, coin(), coin(), coin(), any_byte());
      vsync_pulse();
      repeat (4) scan_line(2, 1'b0, 1'b0);
      send_sample(1'b0, 1'b0, 1'b1, 1'b0, any_byte());
   endtask

   task automatic test_random(input int sample_goal);
      int base_count;
      logic [7:0] first, stop;
      base_count = samples_sent;
      while (samples_sent - base_count < sample_goal) begin
         first = 8'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0: stop = 8'd255;
            1: stop = 8'($urandom_range(0, first));
            default: stop = first + 8'($urandom_range(1, 5));
         endcase
         set_window(first, stop, coin());
         repeat ($urandom_range(1, 3)) random_frame();
      end
   endtask

   // inverted window: no stop line, the frame ends only on a vsync rise
   task automatic test_inverted_window();
      set_window(8'd3, 8'd1, 1'b0);
      send_sample(1'b1, 1'b0, 1'b0, 1'b0, any_byte());
      vsync_pulse();
      repeat (6) scan_line(2, 1'b0, 1'b0);
      send_sample(1'b0, 1'b1, 1'b0, 1'b0, any_byte());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(12, 74);
      test_directed();
      test_window_limits();
      test_random(100);

      set_idling(74, 12);
      test_random(100);
      test_inverted_window();

      set_idling(0, 0);
      test_random(100);

      flush_results();
      if (mismatch_count == 0)
         $display("camera_line_window_capture regression: pass");
      else
         $display("camera_line_window_capture regression: fail");
      $finish;
   end

endmodule
